### rtl/core/tpb_pkg.sv
// Shared types and constants for the threshold-promoted page buffer.
`default_nettype none

package tpb_pkg;

  // Width and reset value of the promotion threshold register.
  localparam int unsigned THRESH_W = 8;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;

  typedef enum logic [0:0] {
    OP_ACCESS = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

endpackage

`default_nettype wire

### rtl/core/tpb_match.sv
// Parallel key compare with first-match selection over the valid entries.
`default_nettype none

module tpb_match #(
  parameter int unsigned DEPTH       = 4,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned COUNT_WIDTH = 8,
  parameter int unsigned POS_W       = 2,
  parameter int unsigned OCC_W       = 3
) (
  input  wire logic [KEY_WIDTH-1:0]                  key_i,
  input  wire logic [DEPTH-1:0][KEY_WIDTH-1:0]       keys_i,
  input  wire logic [DEPTH-1:0][COUNT_WIDTH-1:0]     counts_i,
  input  wire logic [OCC_W-1:0]                      used_i,
  output logic                                       hit_o,
  output logic [DEPTH-1:0]                           sel_o,
  output logic [POS_W-1:0]                           pos_o,
  output logic [COUNT_WIDTH-1:0]                     count_o
);

  logic [DEPTH-1:0] eq;
  logic             seen;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq[i] = (OCC_W'(i) < used_i) && (keys_i[i] == key_i);
    end
  end

  // Keep only the match nearest the front.
  always_comb begin
    seen  = 1'b0;
    sel_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_o[i] = eq[i] & ~seen;
      seen     = seen | eq[i];
    end
  end

  assign hit_o = |eq;

  // The selection is one-hot, so an AND-OR gives the position and the count.
  always_comb begin
    pos_o   = '0;
    count_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_o   = pos_o   | ({POS_W{sel_o[i]}} & POS_W'(i));
      count_o = count_o | ({COUNT_WIDTH{sel_o[i]}} & counts_i[i]);
    end
  end

endmodule

`default_nettype wire

### rtl/core/threshold_promote_page_buffer.sv
// Top level of the threshold-promoted page buffer: entry storage, update and result register.
`default_nettype none

// An item (an access or a clear) is taken whenever start is high; busy is never raised,
// so one item can be given in every cycle. The item is held in an input register, and
// in the following cycle one pass of logic compares the key against all entries,
// updates the counter and reorders the buffer (a clear only empties it); the result is
// registered and shown on the outputs with done_o high for exactly one cycle. The
// receiver cannot stall, so each result must be captured in its strobe cycle. The
// combinational compare and shift across all DEPTH entries sets the clock period.
// The promotion threshold should be written only while no item is in flight.
module threshold_promote_page_buffer #(
  parameter int unsigned DEPTH       = 4,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned COUNT_WIDTH = 8,
  localparam int unsigned POS_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned OCC_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op_i,
  input  wire logic [KEY_WIDTH-1:0]          page_key_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [tpb_pkg::THRESH_W-1:0]  cfg_wdata_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic [POS_W-1:0]                   hit_position_o,
  output logic [COUNT_WIDTH-1:0]             new_count_o,
  output logic                               promoted_o,
  output logic                               evicted_o,
  output logic [KEY_WIDTH-1:0]               evicted_key_o,
  output logic [OCC_W-1:0]                   occupancy_o
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > tpb_pkg::THRESH_W) ? COUNT_WIDTH : tpb_pkg::THRESH_W;

  // Input register.
  logic                  in_vld_q;
  tpb_pkg::op_e          in_op_q;
  logic [KEY_WIDTH-1:0]  in_key_q;

  // Entry storage; only positions below used_q are ever meaningful.
  logic [DEPTH-1:0][KEY_WIDTH-1:0]   key_q, key_d;
  logic [DEPTH-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [OCC_W-1:0]                  used_q, used_d;
  logic [tpb_pkg::THRESH_W-1:0]      thresh_q;

  // Result register.
  logic                   done_q, hit_q, prom_q, evict_q;
  logic [POS_W-1:0]       pos_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [KEY_WIDTH-1:0]   evkey_q;
  logic [OCC_W-1:0]       occ_q;

  logic                   m_hit;
  logic [DEPTH-1:0]       m_sel;
  logic [POS_W-1:0]       m_pos;
  logic [COUNT_WIDTH-1:0] m_count;

  logic                   access;
  logic                   full;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   prom;
  logic [DEPTH-1:0]       upto_hit;

  assign busy = 1'b0;

  tpb_match #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .POS_W       (POS_W),
    .OCC_W       (OCC_W)
  ) u_match (
    .key_i    (in_key_q),
    .keys_i   (key_q),
    .counts_i (cnt_q),
    .used_i   (used_q),
    .hit_o    (m_hit),
    .sel_o    (m_sel),
    .pos_o    (m_pos),
    .count_o  (m_count)
  );

  assign access  = in_vld_q && (in_op_q == tpb_pkg::OP_ACCESS);
  assign full    = (used_q == OCC_W'(DEPTH));
  assign cnt_new = (m_count == {COUNT_WIDTH{1'b1}}) ? m_count : m_count + COUNT_WIDTH'(1);
  assign prom    = m_hit && (CMP_W'(cnt_new) > CMP_W'(thresh_q));

  // Positions at or in front of the hit entry; these shift back on a promotion.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      upto_hit[i] = |(m_sel >> i);
    end
  end

  always_comb begin
    key_d  = key_q;
    cnt_d  = cnt_q;
    used_d = used_q;
    if (in_vld_q && (in_op_q == tpb_pkg::OP_CLEAR)) begin
      used_d = '0;
    end else if (access) begin
      if (m_hit) begin
        if (prom) begin
          key_d[0] = in_key_q;
          cnt_d[0] = cnt_new;
          for (int i = 1; i < DEPTH; i++) begin
            if (upto_hit[i]) begin
              key_d[i] = key_q[i-1];
              cnt_d[i] = cnt_q[i-1];
            end
          end
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (m_sel[i]) begin
              cnt_d[i] = cnt_new;
            end
          end
        end
      end else begin
        // A miss pushes every entry back by one; the tail falls off when full.
        key_d[0] = in_key_q;
        cnt_d[0] = COUNT_WIDTH'(1);
        for (int i = 1; i < DEPTH; i++) begin
          key_d[i] = key_q[i-1];
          cnt_d[i] = cnt_q[i-1];
        end
        if (!full) begin
          used_d = used_q + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      used_q   <= '0;
      thresh_q <= tpb_pkg::THRESH_RESET;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
      used_q   <= used_d;
      done_q   <= in_vld_q;
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_op_q  <= tpb_pkg::op_e'(op_i);
      in_key_q <= page_key_i;
    end
    key_q   <= key_d;
    cnt_q   <= cnt_d;
    hit_q   <= access && m_hit;
    pos_q   <= (access && m_hit) ? m_pos : '0;
    count_q <= !access ? '0 : (m_hit ? cnt_new : COUNT_WIDTH'(1));
    prom_q  <= access && prom;
    evict_q <= access && !m_hit && full;
    evkey_q <= (access && !m_hit && full) ? key_q[DEPTH-1] : '0;
    occ_q   <= used_d;
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign hit_position_o = pos_q;
  assign new_count_o    = count_q;
  assign promoted_o     = prom_q;
  assign evicted_o      = evict_q;
  assign evicted_key_o  = evkey_q;
  assign occupancy_o    = occ_q;

  // Every accepted item produces its result once it has passed the input and result registers.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("item accepted without a result two cycles later");

  // Fill level never exceeds the number of entries.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= OCC_W'(DEPTH))
    else $error("fill level beyond buffer depth");

  // An eviction only happens on a miss and leaves the buffer full.
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> (!hit_o && occupancy_o == OCC_W'(DEPTH)))
    else $error("eviction without a full buffer");

  // A promotion implies a hit whose count passed the threshold.
  a_prom_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && promoted_o) |-> (hit_o && CMP_W'(new_count_o) > CMP_W'(thresh_q)))
    else $error("promotion without a qualifying hit");

  // A miss leaves the position and promotion flag clear.
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_position_o == '0 && !promoted_o))
    else $error("miss reported with position or promotion");

endmodule

`default_nettype wire

### verif/tpb_tb_pkg.sv
// Scoreboard for the page buffer testbench: a predictor of the buffer and the queue of awaited results.
package tpb_tb_pkg;

  localparam int unsigned BUF_DEPTH = 4;
  localparam logic [7:0]  COUNT_SAT = 8'hFF;

  typedef struct {
    logic        hit;
    logic [1:0]  position;
    logic [7:0]  count;
    logic        promoted;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [2:0]  occupancy;
  } access_result_t;

  class page_buffer_scoreboard;
    logic [31:0]    slot_key [BUF_DEPTH];
    logic [7:0]     slot_count [BUF_DEPTH];
    int unsigned    fill;
    logic [7:0]     threshold;
    access_result_t awaited [$];
    int unsigned    errors;
    int unsigned    items;
    int unsigned    clears;
    int unsigned    hits;
    int unsigned    promotions;
    int unsigned    evictions;
    int unsigned    saturations;

    function new();
      fill        = 0;
      threshold   = tpb_pkg::THRESH_RESET;
      errors      = 0;
      items       = 0;
      clears      = 0;
      hits        = 0;
      promotions  = 0;
      evictions   = 0;
      saturations = 0;
    endfunction

    function void set_threshold(logic [7:0] value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Works out the result of one accepted item and updates the buffer copy.
    function void note_item(tpb_pkg::op_e op, logic [31:0] key);
      access_result_t r;
      int unsigned    found;
      r = '{default: '0};
      found = BUF_DEPTH;
      items++;
      if (op == tpb_pkg::OP_CLEAR) begin
        fill = 0;
        clears++;
      end else begin
        for (int unsigned i = 0; i < fill; i++) begin
          if (found == BUF_DEPTH && slot_key[i] == key) begin
            found = i;
          end
        end
        if (found < fill) begin
          hits++;
          r.hit      = 1'b1;
          r.position = 2'(found);
          r.count    = slot_count[found];
          if (r.count != COUNT_SAT) begin
            r.count++;
          end else begin
            saturations++;
          end
          slot_count[found] = r.count;
          if (r.count > threshold) begin
            // An entry already at the front is reported as promoted but stays put.
            promotions++;
            r.promoted = 1'b1;
            for (int unsigned i = found; i > 0; i--) begin
              slot_key[i]   = slot_key[i-1];
              slot_count[i] = slot_count[i-1];
            end
            slot_key[0]   = key;
            slot_count[0] = r.count;
          end
        end else begin
          if (fill == BUF_DEPTH) begin
            evictions++;
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[BUF_DEPTH-1];
            fill--;
          end
          for (int unsigned i = fill; i > 0; i--) begin
            slot_key[i]   = slot_key[i-1];
            slot_count[i] = slot_count[i-1];
          end
          slot_key[0]   = key;
          slot_count[0] = 8'd1;
          fill++;
          r.count = 8'd1;
        end
      end
      r.occupancy = 3'(fill);
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(access_result_t got);
      access_result_t want;
      if (awaited.size() == 0) begin
        $error("result strobe with no item outstanding");
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("hit_position", want.position, got.position);
      compare_field("new_count", want.count, got.count);
      compare_field("promoted", want.promoted, got.promoted);
      compare_field("evicted", want.evicted, got.evicted);
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

endpackage

### verif/tb_threshold_promote_page_buffer.sv
// Testbench top for the threshold-promoted page buffer: stimulus, result monitor and run control.
module tb_threshold_promote_page_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        op_i        = tpb_pkg::OP_ACCESS;
  logic [31:0] page_key_i  = '0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        busy;
  logic        done_o;
  logic        hit_o;
  logic [1:0]  hit_position_o;
  logic [7:0]  new_count_o;
  logic        promoted_o;
  logic        evicted_o;
  logic [31:0] evicted_key_o;
  logic [2:0]  occupancy_o;

  tpb_tb_pkg::page_buffer_scoreboard sb;
  tpb_tb_pkg::access_result_t        observed;
  int unsigned                       burst_left;

  threshold_promote_page_buffer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .page_key_i     (page_key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .hit_position_o (hit_position_o),
    .new_count_o    (new_count_o),
    .promoted_o     (promoted_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o),
    .occupancy_o    (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // Everything is sampled at the edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.set_threshold(cfg_wdata_i);
      end
      if (start && !busy) begin
        sb.note_item(tpb_pkg::op_e'(op_i), page_key_i);
      end
      if (done_o) begin
        observed.hit         = hit_o;
        observed.position    = hit_position_o;
        observed.count       = new_count_o;
        observed.promoted    = promoted_o;
        observed.evicted     = evicted_o;
        observed.evicted_key = evicted_key_o;
        observed.occupancy   = occupancy_o;
        sb.check_result(observed);
      end
    end
  end

  // The sender works in bursts; between bursts it may drop start and go quiet.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_item(input tpb_pkg::op_e op, input logic [31:0] key);
    start      <= 1'b1;
    op_i       <= op;
    page_key_i <= key;
    do @(posedge clk_i); while (busy);
    pace();
  endtask

  // Holds the sender off until every awaited result has come, then lets the clock run on with start low.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly keys from a small pool so that hits and promotions are frequent, with some
  // fresh keys and the odd clear mixed in.
  task automatic run_phase(input logic [7:0] thr, input int unsigned n, input bit hammer);
    logic [31:0] pool [8];
    int unsigned pool_n;
    int unsigned pick;
    write_threshold(thr);
    pool_n = $urandom_range(2, 8);
    foreach (pool[i]) begin
      pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom();
    end
    // A long run on one key drives its counter into saturation.
    if (hammer) begin
      repeat (270) send_item(tpb_pkg::OP_ACCESS, pool[0]);
    end
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(tpb_pkg::OP_CLEAR, $urandom());
      end else if (pick < 13) begin
        send_item(tpb_pkg::OP_ACCESS, $urandom());
      end else begin
        send_item(tpb_pkg::OP_ACCESS, pool[$urandom_range(0, pool_n - 1)]);
      end
    end
  endtask

  initial begin
    logic [7:0]  thr;
    logic [7:0]  thr_list [6];
    int unsigned phase;
    sb = new();
    burst_left = 1;
    thr_list = '{8'd0, 8'd255, 8'd1, 8'd254, tpb_pkg::THRESH_RESET, 8'd3};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset threshold: clear of an empty buffer, extreme keys,
    // filling up, eviction of the tail, climbing to promotion and promotion at the front.
    send_item(tpb_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    send_item(tpb_pkg::OP_ACCESS, 32'h0000_0000);
    send_item(tpb_pkg::OP_ACCESS, 32'hFFFF_FFFF);
    send_item(tpb_pkg::OP_ACCESS, 32'h0000_0000);
    send_item(tpb_pkg::OP_ACCESS, 32'hA5A5_5A5A);
    send_item(tpb_pkg::OP_ACCESS, 32'h1234_5678);
    send_item(tpb_pkg::OP_ACCESS, 32'hDEAD_BEEF);
    repeat (6) send_item(tpb_pkg::OP_ACCESS, 32'hFFFF_FFFF);
    send_item(tpb_pkg::OP_ACCESS, 32'hA5A5_5A5A);
    send_item(tpb_pkg::OP_CLEAR, 32'h5A5A_A5A5);
    send_item(tpb_pkg::OP_ACCESS, 32'hFFFF_FFFF);
    send_item(tpb_pkg::OP_ACCESS, 32'h0000_0001);

    phase = 0;
    while (sb.items < 2000) begin
      thr = (phase < 6) ? thr_list[phase] : 8'($urandom_range(0, 255));
      run_phase(thr, $urandom_range(150, 300), thr >= 8'd254);
      phase++;
    end

    start <= 1'b0;
    for (int c = 0; c < 64 && sb.pending() != 0; c++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end

    $display("summary: %0d items over %0d threshold settings, %0d clears, %0d hits",
             sb.items, phase, sb.clears, sb.hits);
    $display("summary: %0d promotions, %0d evictions, %0d hits on a saturated counter",
             sb.promotions, sb.evictions, sb.saturations);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
